FILE: src/lih_pkg.sv
// Shared types, codes and helpers of the local IPv4 address hash table.
// No dependencies; used by local_ip_hash_table.
`timescale 1ns / 1ps
`default_nettype none

package lih_pkg;

    localparam int DEFAULT_BUCKETS = 64;
    localparam int DEFAULT_WAYS    = 4;

    localparam int ADDR_W = 32;
    localparam int MASK_W = 32;
    localparam int DEV_W  = 8;
    localparam int CMD_W  = 2;
    localparam int STAT_W = 2;
    localparam int SUM_W  = 10;

    localparam logic [7:0] BYTE_MASK = 8'hff;

    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

    localparam logic [STAT_W-1:0] STATUS_DONE     = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_DUP      = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_FULL     = 2'd2;
    localparam logic [STAT_W-1:0] STATUS_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [MASK_W-1:0] mask;
        logic [DEV_W-1:0]  dev;
    } t_entry;

    // Sum of the four address bytes; the caller keeps the low bucket bits.
    function automatic logic [SUM_W-1:0] byte_sum(input logic [ADDR_W-1:0] a);
        logic [SUM_W-1:0] s;
        s = SUM_W'(a[7:0] & BYTE_MASK) + SUM_W'(a[15:8] & BYTE_MASK)
          + SUM_W'(a[23:16] & BYTE_MASK) + SUM_W'(a[31:24] & BYTE_MASK);
        return s;
    endfunction

endpackage

`default_nettype wire

FILE: src/local_ip_hash_table.sv
// Top level of the local IPv4 address hash table: request handshake,
// bucket memories and lookup/update logic. Depends on lih_pkg.
`timescale 1ns / 1ps
`default_nettype none

// The table holds up to BUCKETS*WAYS local IPv4 addresses, each with its
// netmask and device number. An address lives in the bucket given by the sum
// of its four bytes, taken modulo BUCKETS (which must be a power of two), and
// in the lowest free way of that bucket. Each request (lookup, insert or
// delete) gives exactly one result with hit, the stored mask and device of a
// matching entry (zero on a miss) and a status code. When a request is
// accepted, the bucket row is read from the entry and valid memories into
// registers; in the compare state after that the ways are compared and the
// modified row is written back. The next request is accepted only once this
// read-modify-write pass over the bucket memories has ended. The result
// sits in an output register, so a new request is accepted while the last
// result waits to be taken; only when that register is still full at the end
// of a lookup does the block hold the request until it drains. After reset a
// clearing pass zeroes every bucket of the valid memory, and no request is
// accepted during that time. Entry data that was never written is never
// read as a match, since its valid bit stays low.
module local_ip_hash_table #(
    parameter int BUCKETS = lih_pkg::DEFAULT_BUCKETS,
    parameter int WAYS    = lih_pkg::DEFAULT_WAYS
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    output logic                         o_in_ready,
    input  wire  [lih_pkg::CMD_W-1:0]    i_cmd,
    input  wire  [lih_pkg::ADDR_W-1:0]   i_ip_addr,
    input  wire  [lih_pkg::MASK_W-1:0]   i_ip_mask,
    input  wire  [lih_pkg::DEV_W-1:0]    i_dev_index,
    output logic                         o_out_valid,
    input  wire                          i_out_ready,
    output logic                         o_hit,
    output logic [lih_pkg::MASK_W-1:0]   o_found_mask,
    output logic [lih_pkg::DEV_W-1:0]    o_found_dev,
    output logic [lih_pkg::STAT_W-1:0]   o_status
);

    localparam int BW = $clog2(BUCKETS);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP
    } t_state;

    t_state r_state;
    logic [BW-1:0] r_clr_idx;

    // Request captured at acceptance.
    logic [lih_pkg::CMD_W-1:0]  r_cmd;
    logic [lih_pkg::ADDR_W-1:0] r_addr;
    logic [lih_pkg::MASK_W-1:0] r_mask;
    logic [lih_pkg::DEV_W-1:0]  r_dev;
    logic [BW-1:0]              r_bucket;

    // Result register.
    logic                         r_out_valid;
    logic                         r_hit;
    logic [lih_pkg::MASK_W-1:0]   r_found_mask;
    logic [lih_pkg::DEV_W-1:0]    r_found_dev;
    logic [lih_pkg::STAT_W-1:0]   r_status;

    // Bucket memories and their registered read data.
    lih_pkg::t_entry [WAYS-1:0] r_data_mem [BUCKETS];
    logic [WAYS-1:0]            r_valid_mem [BUCKETS];
    lih_pkg::t_entry [WAYS-1:0] r_rd_row;
    logic [WAYS-1:0]            r_rd_valid;

    logic                         in_accept;
    logic [BW-1:0]                in_bucket;
    logic                         commit;
    logic [WAYS-1:0]              match;
    logic [WAYS-1:0]              free_oh;
    logic                         hit;
    logic                         full;
    logic [lih_pkg::MASK_W-1:0]   f_mask;
    logic [lih_pkg::DEV_W-1:0]    f_dev;
    logic [lih_pkg::STAT_W-1:0]   n_status;
    lih_pkg::t_entry [WAYS-1:0]   n_row;
    logic [WAYS-1:0]              n_valid;
    logic                         data_we;
    logic                         valid_we;
    logic [BW-1:0]                valid_waddr;
    logic [WAYS-1:0]              valid_wdata;
    logic [lih_pkg::SUM_W-1:0]    in_sum;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_accept  = i_in_valid && o_in_ready;
    assign in_sum     = lih_pkg::byte_sum(i_ip_addr);
    assign in_bucket  = in_sum[BW-1:0];

    // The lookup finishes once the result register is free or being drained.
    assign commit = (r_state == S_LOOKUP) && (!r_out_valid || i_out_ready);

    // Compare all ways of the bucket; at most one can match.
    always_comb begin
        f_mask = '0;
        f_dev  = '0;
        for (int w = 0; w < WAYS; w++) begin
            match[w] = r_rd_valid[w] && (r_rd_row[w].addr == r_addr);
            if (match[w]) begin
                f_mask = f_mask | r_rd_row[w].mask;
                f_dev  = f_dev | r_rd_row[w].dev;
            end
        end
    end

    assign hit     = |match;
    assign full    = &r_rd_valid;
    // Lowest clear valid bit of the bucket.
    assign free_oh = ~r_rd_valid & (r_rd_valid + WAYS'(1));

    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            n_row[w] = free_oh[w]
                     ? lih_pkg::t_entry'{addr: r_addr, mask: r_mask, dev: r_dev}
                     : r_rd_row[w];
        end
    end

    always_comb begin
        n_valid  = r_rd_valid;
        data_we  = 1'b0;
        valid_we = 1'b0;
        unique case (r_cmd)
            lih_pkg::CMD_INSERT: begin
                if (hit) begin
                    n_status = lih_pkg::STATUS_DUP;
                end else if (full) begin
                    n_status = lih_pkg::STATUS_FULL;
                end else begin
                    n_status = lih_pkg::STATUS_DONE;
                    n_valid  = r_rd_valid | free_oh;
                    data_we  = commit;
                    valid_we = commit;
                end
            end
            lih_pkg::CMD_DELETE: begin
                if (hit) begin
                    n_status = lih_pkg::STATUS_DONE;
                    n_valid  = r_rd_valid & ~match;
                    valid_we = commit;
                end else begin
                    n_status = lih_pkg::STATUS_NOTFOUND;
                end
            end
            default: begin
                // Lookup, and the unused code that behaves as one.
                n_status = hit ? lih_pkg::STATUS_DONE : lih_pkg::STATUS_NOTFOUND;
            end
        endcase
    end

    // The clearing pass owns the valid write port right after reset.
    always_comb begin
        if (r_state == S_CLEAR) begin
            valid_waddr = r_clr_idx;
            valid_wdata = '0;
        end else begin
            valid_waddr = r_bucket;
            valid_wdata = n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (data_we) begin
            r_data_mem[r_bucket] <= n_row;
        end
        if (in_accept) begin
            r_rd_row <= r_data_mem[in_bucket];
        end
    end

    always_ff @(posedge i_clk) begin
        if (valid_we || (r_state == S_CLEAR)) begin
            r_valid_mem[valid_waddr] <= valid_wdata;
        end
        if (in_accept) begin
            r_rd_valid <= r_valid_mem[in_bucket];
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_cmd    <= i_cmd;
            r_addr   <= i_ip_addr;
            r_mask   <= i_ip_mask;
            r_dev    <= i_dev_index;
            r_bucket <= in_bucket;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_idx <= r_clr_idx + BW'(1);
                    if (r_clr_idx == BW'(BUCKETS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_accept) begin
                        r_state <= S_LOOKUP;
                    end
                end
                S_LOOKUP: begin
                    if (commit) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_CLEAR;
                end
            endcase

            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end

        if (commit) begin
            r_hit        <= hit;
            r_found_mask <= f_mask;
            r_found_dev  <= f_dev;
            r_status     <= n_status;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_hit        = r_hit;
    assign o_found_mask = r_found_mask;
    assign o_found_dev  = r_found_dev;
    assign o_status     = r_status;

`ifndef SYNTH
    // An accepted request always moves on to the compare cycle.
    a_accept_to_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == S_LOOKUP))
        else $error("accepted request did not enter the compare cycle");

    // A miss carries no stored mask or device.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_hit) |-> (o_found_mask == '0 && o_found_dev == '0))
        else $error("miss result carries stored data");

    // A duplicate insert is always a hit.
    a_dup_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == lih_pkg::STATUS_DUP) |-> o_hit)
        else $error("duplicate status without a hit");

    // Full bucket and not found are always misses.
    a_miss_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == lih_pkg::STATUS_FULL ||
                         o_status == lih_pkg::STATUS_NOTFOUND)) |-> !o_hit)
        else $error("miss status reported with a hit");
`endif

endmodule

`default_nettype wire
